@@ rtl/cbfa_pkg.sv @@
package cbfa_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int OUT_WIDTH   = 16;
  localparam int OUT_FRAC    = OUT_WIDTH - 2;
  localparam int STAGES      = 16;
  localparam int ATAN_ENTRIES = 30;
  localparam int N_STAGES    = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

  // cordic datapath width: q30 values stay well below 2^32
  localparam int CW = 34;
  // root is about 2^30..2^30.5, inv_len below 2^31
  localparam int SQ_IN_W  = 62;
  localparam int ROOT_W   = 31;
  localparam int SQ_STEPS = ROOT_W;
  localparam int DIV_W    = 61;
  localparam int QUO_W    = 31;

  localparam logic [41:0] TURN_SCALE = 42'd1399941684381;
  localparam logic signed [CW-1:0] CORDIC_K = CW'(652032874);
  localparam logic [60:0] ONE_Q60 = 61'(1) << 60;
  localparam logic [61:0] ONE_Q30 = 62'(1) << 30;

  typedef logic signed [CW-1:0] cw_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    logic signed [32:0] z;
  } rot_t;

  function automatic logic signed [32:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; default: t = 32'h00000001;
    endcase
    return $signed({1'b0, t});
  endfunction

  // q30 product, round half up
  function automatic cw_t mul_q30(input cw_t a, input cw_t b);
    logic signed [2*CW-1:0] p;
    p = a * b + (2*CW)'(64'sd1 <<< 29);
    return CW'(p >>> 30);
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input cw_t v);
    cw_t r;
    cw_t one;
    one = CW'(1) <<< OUT_FRAC;
    r = (v + (CW'(1) <<< (29 - OUT_FRAC))) >>> (30 - OUT_FRAC);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[OUT_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/camera_basis_from_angles_unit.sv @@
// camera view basis from azimuth and elevation. a fully pipelined chain of cells:
// a phase stage, a cordic rotation chain (one cell per stage, both angles side by
// side), a quadrant fixup stage, a restoring square-root chain (31 cells), a
// restoring divide chain (31 cells) for 1/len, then two multiply stages and an
// output register. one beat is accepted every cycle while the output is not
// stalled. the whole pipe stalls while the output beat waits, and a skid register
// keeps s_axis_tready independent of m_axis_tready.
module camera_basis_from_angles_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [2*cbfa_pkg::ANGLE_WIDTH-1:0]  s_axis_tdata,   // phi, theta from lsb
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [8*cbfa_pkg::OUT_WIDTH-1:0]    m_axis_tdata   // dir_x, dir_y, dir_z,
                                                             // right_x, right_z,
                                                             // up_x, up_y, up_z from lsb
);
  import cbfa_pkg::*;

  localparam int LAT = 2 + N_STAGES + SQ_STEPS + QUO_W + 3;

  // skid buffer on the input side
  logic                     skid_vld_q;
  logic [2*ANGLE_WIDTH-1:0] skid_q;
  logic                     en;
  logic                     in_vld;
  logic [2*ANGLE_WIDTH-1:0] in_dat;

  assign s_axis_tready = !skid_vld_q;
  assign in_vld = skid_vld_q | s_axis_tvalid;
  assign in_dat = skid_vld_q ? skid_q : s_axis_tdata;

  logic [LAT-1:0] vld_q;
  assign en = !(m_axis_tvalid && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
      vld_q      <= '0;
    end else begin
      if (!en && s_axis_tvalid && s_axis_tready) skid_vld_q <= 1'b1;
      else if (en) skid_vld_q <= 1'b0;
      if (en) vld_q <= {vld_q[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) skid_q <= s_axis_tdata;
  end

  assign m_axis_tvalid = vld_q[LAT-1];

  // every pipe register, inside the cells too, advances only on en

  // phase stage: angle times turn scale, quadrant rounding
  logic [1:0] quad_q [2];
  logic signed [32:0] res_q [2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        logic [63:0] prod;
        logic [31:0] ph, ru;
        logic [1:0]  qd;
        prod = 64'($signed(in_dat[ANGLE_WIDTH*k +: ANGLE_WIDTH])) * 64'(TURN_SCALE);
        ph = prod[55:24];
        qd = 2'((ph + 32'h20000000) >> 30);
        ru = ph - {qd, 30'd0};
        quad_q[k] <= qd;
        res_q[k]  <= $signed({ru[31], ru});
      end
    end
  end

  // cordic chain, quadrant carried alongside
  rot_t [1:0] rot [N_STAGES+1];
  logic [1:0] qd_pipe [N_STAGES+1][2];

  for (genvar k = 0; k < 2; k++) begin : g_seed
    assign rot[0][k] = '{x: CORDIC_K, y: '0, z: res_q[k]};
    assign qd_pipe[0][k] = quad_q[k];
  end

  for (genvar g = 0; g < N_STAGES; g++) begin : g_rot
    logic [1:0] qd_q [2];
    cbfa_rot_cell u_cell (
      .clk_i(clk_i), .en_i(en), .idx_i(5'(g)), .rot_i(rot[g]), .rot_o(rot[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        qd_q[0] <= qd_pipe[g][0];
        qd_q[1] <= qd_pipe[g][1];
      end
    end
    assign qd_pipe[g+1][0] = qd_q[0];
    assign qd_pipe[g+1][1] = qd_q[1];
  end

  // quadrant fixup
  cw_t cp_q, sp_q, st_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cw_t c[2], s[2];
      for (int k = 0; k < 2; k++) begin
        case (qd_pipe[N_STAGES][k])
          2'd0: begin c[k] = rot[N_STAGES][k].x;  s[k] = rot[N_STAGES][k].y;  end
          2'd1: begin c[k] = -rot[N_STAGES][k].y; s[k] = rot[N_STAGES][k].x;  end
          2'd2: begin c[k] = -rot[N_STAGES][k].x; s[k] = -rot[N_STAGES][k].y; end
          default: begin c[k] = rot[N_STAGES][k].y; s[k] = -rot[N_STAGES][k].x; end
        endcase
      end
      cp_q <= c[0];
      sp_q <= s[0];
      st_q <= s[1];
    end
  end

  // square root chain, with sin/cos carried alongside
  localparam int SIDE = 3 * CW;
  logic [SQ_IN_W-1:0] srem [SQ_STEPS+1];
  logic [ROOT_W-1:0]  sroot [SQ_STEPS+1];
  logic [SIDE-1:0]    sside [SQ_STEPS+1];
  cw_t sq_v;
  assign sq_v = mul_q30(st_q, st_q);
  assign srem[0]  = (ONE_Q30 + SQ_IN_W'($unsigned(sq_v))) << 30;
  assign sroot[0] = '0;
  assign sside[0] = {cp_q, sp_q, st_q};

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    logic [SIDE-1:0] side_q;
    cbfa_sqrt_cell u_cell (
      .clk_i(clk_i), .en_i(en), .idx_i(5'(g)), .rem_i(srem[g]), .root_i(sroot[g]),
      .rem_o(srem[g+1]), .root_o(sroot[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) side_q <= sside[g];
    end
    assign sside[g+1] = side_q;
  end

  // divide chain for (2^60 + root/2) / root
  logic [DIV_W:0]     drem [QUO_W+1];
  logic [ROOT_W-1:0]  dden [QUO_W+1];
  logic [QUO_W-1:0]   dquo [QUO_W+1];
  logic [SIDE-1:0]    dside [QUO_W+1];
  assign drem[0]  = {1'b0, ONE_Q60 + 61'(sroot[SQ_STEPS] >> 1)};
  assign dden[0]  = sroot[SQ_STEPS];
  assign dquo[0]  = '0;
  assign dside[0] = sside[SQ_STEPS];

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    logic [SIDE-1:0] side_q;
    cbfa_div_cell u_cell (
      .clk_i(clk_i), .en_i(en), .idx_i(5'(g)), .rem_i(drem[g]), .den_i(dden[g]),
      .quo_i(dquo[g]), .rem_o(drem[g+1]), .den_o(dden[g+1]), .quo_o(dquo[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) side_q <= dside[g];
    end
    assign dside[g+1] = side_q;
  end

  // multiply stages: products of sines and cosines first, then scaling by 1/len
  cw_t cp_side, sp_side, st_side;
  cw_t il_q, cp2_q, sp2_q, st2_q, cs_q, ss_q;
  cw_t m_dx_q, m_dy_q, m_dz_q, m_ux_q, m_uz_q, m_il_q, m_sp_q, m_cp_q;
  logic [8*OUT_WIDTH-1:0] out_q;
  assign {cp_side, sp_side, st_side} = dside[QUO_W];
  always_ff @(posedge clk_i) begin
    if (en) begin
      il_q  <= cw_t'(dquo[QUO_W]);
      cp2_q <= cp_side;
      sp2_q <= sp_side;
      st2_q <= st_side;
      cs_q  <= mul_q30(cp_side, st_side);
      ss_q  <= mul_q30(sp_side, st_side);
      m_dx_q <= mul_q30(cp2_q, il_q);
      m_dy_q <= mul_q30(st2_q, il_q);
      m_dz_q <= mul_q30(sp2_q, il_q);
      m_ux_q <= mul_q30(cs_q, il_q);
      m_uz_q <= mul_q30(ss_q, il_q);
      m_il_q <= il_q;
      m_sp_q <= sp2_q;
      m_cp_q <= cp2_q;
      out_q <= {to_out(-m_uz_q), to_out(m_il_q), to_out(-m_ux_q), to_out(m_cp_q),
                to_out(-m_sp_q), to_out(m_dz_q), to_out(m_dy_q), to_out(m_dx_q)};
    end
  end
  assign m_axis_tdata = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !s_axis_tready)
    else $error("skid full but ready high");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipe moved during stall");
endmodule

@@ rtl/cbfa_rot_cell.sv @@
module cbfa_rot_cell (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [4:0]            idx_i,
  input  cbfa_pkg::rot_t [1:0]  rot_i,
  output cbfa_pkg::rot_t [1:0]  rot_o
);
  import cbfa_pkg::*;

  rot_t [1:0] r_d, r_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (!rot_i[k].z[32]) begin
        r_d[k].x = rot_i[k].x - (rot_i[k].y >>> idx_i);
        r_d[k].y = rot_i[k].y + (rot_i[k].x >>> idx_i);
        r_d[k].z = rot_i[k].z - atan_turn(int'(idx_i));
      end else begin
        r_d[k].x = rot_i[k].x + (rot_i[k].y >>> idx_i);
        r_d[k].y = rot_i[k].y - (rot_i[k].x >>> idx_i);
        r_d[k].z = rot_i[k].z + atan_turn(int'(idx_i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r_q <= r_d;
  end

  assign rot_o = r_q;
endmodule

@@ rtl/cbfa_sqrt_cell.sv @@
module cbfa_sqrt_cell (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [4:0]                     idx_i,
  input  logic [cbfa_pkg::SQ_IN_W-1:0]   rem_i,
  input  logic [cbfa_pkg::ROOT_W-1:0]    root_i,
  output logic [cbfa_pkg::SQ_IN_W-1:0]   rem_o,
  output logic [cbfa_pkg::ROOT_W-1:0]    root_o
);
  import cbfa_pkg::*;

  logic [SQ_IN_W:0] trial;
  logic [SQ_IN_W-1:0] rem_d, rem_q;
  logic [ROOT_W-1:0] root_d, root_q;
  int b;

  // restoring square root, one result bit per cell, msb first
  always_comb begin
    b = ROOT_W - 1 - int'(idx_i);
    trial = ({1'b0, (SQ_IN_W)'(root_i)} << (b + 1)) + ((SQ_IN_W + 1)'(1) << (2 * b));
    if ({1'b0, rem_i} >= trial) begin
      rem_d  = rem_i - trial[SQ_IN_W-1:0];
      root_d = root_i | (ROOT_W'(1) << b);
    end else begin
      rem_d  = rem_i;
      root_d = root_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule

@@ rtl/cbfa_div_cell.sv @@
module cbfa_div_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [4:0]                   idx_i,
  input  logic [cbfa_pkg::DIV_W:0]     rem_i,
  input  logic [cbfa_pkg::ROOT_W-1:0]  den_i,
  input  logic [cbfa_pkg::QUO_W-1:0]   quo_i,
  output logic [cbfa_pkg::DIV_W:0]     rem_o,
  output logic [cbfa_pkg::ROOT_W-1:0]  den_o,
  output logic [cbfa_pkg::QUO_W-1:0]   quo_o
);
  import cbfa_pkg::*;

  logic [DIV_W+QUO_W:0] trial;
  logic [DIV_W:0] rem_d, rem_q;
  logic [ROOT_W-1:0] den_q;
  logic [QUO_W-1:0] quo_d, quo_q;
  int b;

  // restoring division, one quotient bit per cell
  always_comb begin
    b = QUO_W - 1 - int'(idx_i);
    trial = (DIV_W + QUO_W + 1)'(den_i) << b;
    if ((DIV_W + QUO_W + 1)'(rem_i) >= trial) begin
      rem_d = rem_i - trial[DIV_W:0];
      quo_d = quo_i | (QUO_W'(1) << b);
    end else begin
      rem_d = rem_i;
      quo_d = quo_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;
endmodule
